>>> rtl/failure_backoff_skip_macros.svh
// assertion macros for the failure back-off skip block
// no dependencies; checks compile away under SYNTHESIS
`ifndef FAILURE_BACKOFF_SKIP_MACROS_SVH
`define FAILURE_BACKOFF_SKIP_MACROS_SVH

`ifndef SYNTHESIS
`define FBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("failure_backoff_skip: same-cycle check failed");
`define FBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("failure_backoff_skip: next-cycle check failed");
`else
`define FBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/fbs_pkg.sv
// constants and state type for the failure back-off skip block
// no dependencies
package fbs_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int PHASE_W    = 8;

  localparam logic [15:0] MIN_OBSERVATIONS  = 16'd4;
  localparam logic [16:0] DEFAULT_THRESHOLD = 17'd32768;
  localparam logic [16:0] THRESHOLD_ONE     = 17'd65536;
  localparam logic [15:0] DEFAULT_PERIOD    = 16'd4;
  localparam logic [15:0] MIN_MILD_PERIOD   = 16'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV
  } fbs_state_t;

endpackage

>>> rtl/failure_backoff_skip.sv
// failure back-off skip decision: one request in, one skip result out
// path: a throttled request passes ST_MUL, ST_CHK and the ST_DIV steps before out_valid, others end after ST_CHK
// throughput: one request at a time; busy holds through the 8-step phase remainder
// phase store is a 64 x 8 memory with a registered read, per-entry valid bits cleared by reset
// rst_n is synchronous, active low; the receiver cannot stall results
// depends on fbs_pkg and failure_backoff_skip_macros.svh
`include "failure_backoff_skip_macros.svh"

module failure_backoff_skip (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_slot_id,
  input  logic        in_slot_present,
  input  logic [15:0] in_observation_count,
  input  logic [23:0] in_success_weight,
  input  logic [23:0] in_failure_weight,
  input  logic [16:0] in_skip_threshold,
  input  logic [15:0] in_base_period,
  output logic        out_valid,
  output logic        out_skip
);

  fbs_pkg::fbs_state_t state_r, state_nxt;

  logic [fbs_pkg::PHASE_W-1:0] phase_mem [fbs_pkg::SLOT_COUNT];
  logic [fbs_pkg::SLOT_COUNT-1:0] phase_vld_r;
  logic [fbs_pkg::PHASE_W-1:0] rd_data_r;

  logic [fbs_pkg::SLOT_W-1:0] slot_r;
  logic        elig_r;
  logic [23:0] f_r;
  logic [24:0] total_r;
  logic [16:0] thr_r;
  logic [15:0] base_r;
  logic [41:0] prod_r;
  logic        mild_r, severe_r;
  logic [16:0] period_r;
  logic [fbs_pkg::PHASE_W-1:0] div_r, rem_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_skip_r, out_skip_nxt;

  logic        accept;
  logic        below;
  logic        throttle;
  logic [fbs_pkg::PHASE_W-1:0] phase_old, phase_new;
  logic [15:0] half_base;
  logic [16:0] period_sel;
  logic [28:0] f10, t7, t9;
  logic [8:0]  rem_sh;
  logic        rem_ge;
  logic [fbs_pkg::PHASE_W-1:0] rem_step;

  assign accept    = start && !busy;
  assign busy      = (state_r != fbs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_skip  = out_skip_r;

  assign below     = ({2'b00, f_r, 16'h0000} < prod_r);
  assign throttle  = elig_r && !below;
  assign phase_old = phase_vld_r[slot_r] ? rd_data_r : '0;
  assign phase_new = phase_old + 1'b1;
  assign half_base = {1'b0, base_r[15:1]};

  assign f10 = ({5'd0, f_r} << 3) + ({5'd0, f_r} << 1);
  assign t7  = ({4'd0, total_r} << 3) - {4'd0, total_r};
  assign t9  = ({4'd0, total_r} << 3) + {4'd0, total_r};

  always_comb begin
    if (mild_r) begin
      period_sel = (half_base < fbs_pkg::MIN_MILD_PERIOD) ?
                   {1'b0, fbs_pkg::MIN_MILD_PERIOD} : {1'b0, half_base};
    end else if (severe_r) begin
      period_sel = {base_r, 1'b0};
    end else begin
      period_sel = {1'b0, base_r};
    end
  end

  // one restoring step of phase mod period
  assign rem_sh   = {rem_r, div_r[fbs_pkg::PHASE_W-1]};
  assign rem_ge   = ({8'd0, rem_sh} >= period_r);
  assign rem_step = rem_ge ? 8'(rem_sh - period_r[8:0]) : rem_sh[7:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_skip_nxt  = 1'b0;
    unique case (state_r)
      fbs_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = fbs_pkg::ST_MUL;
        end
      end
      fbs_pkg::ST_MUL: begin
        state_nxt = fbs_pkg::ST_CHK;
      end
      fbs_pkg::ST_CHK: begin
        cnt_nxt = '0;
        if (throttle) begin
          state_nxt = fbs_pkg::ST_DIV;
        end else begin
          state_nxt     = fbs_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      fbs_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 3'd7) begin
          state_nxt     = fbs_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          out_skip_nxt  = (rem_step != '0);
        end
      end
      default: begin
        state_nxt = fbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbs_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_skip_r  <= 1'b0;
      phase_vld_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_skip_r  <= out_skip_nxt;
      if (state_r == fbs_pkg::ST_CHK && throttle) begin
        phase_vld_r[slot_r] <= 1'b1;
      end
    end
  end

  // phase memory, read on accept, written back after the threshold check when throttled
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= phase_mem[in_slot_id];
    end
    if (state_r == fbs_pkg::ST_CHK && throttle) begin
      phase_mem[slot_r] <= phase_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r  <= in_slot_id;
      elig_r  <= in_slot_present && (in_observation_count >= fbs_pkg::MIN_OBSERVATIONS)
                 && (in_failure_weight > in_success_weight);
      f_r     <= in_failure_weight;
      total_r <= {1'b0, in_success_weight} + {1'b0, in_failure_weight};
      thr_r   <= (in_skip_threshold == '0 || in_skip_threshold > fbs_pkg::THRESHOLD_ONE) ?
                 fbs_pkg::DEFAULT_THRESHOLD : in_skip_threshold;
      base_r  <= (in_base_period == '0) ? fbs_pkg::DEFAULT_PERIOD : in_base_period;
    end
    if (state_r == fbs_pkg::ST_MUL) begin
      prod_r   <= {25'd0, thr_r} * {17'd0, total_r};
      mild_r   <= (f10 <= t7);
      severe_r <= (f10 > t9);
    end
    if (state_r == fbs_pkg::ST_CHK) begin
      period_r <= period_sel;
      div_r    <= phase_new;
      rem_r    <= '0;
    end
    if (state_r == fbs_pkg::ST_DIV) begin
      div_r <= {div_r[fbs_pkg::PHASE_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  `FBS_ASSERT_IMPL(a_result_when_idle, clk, rst_n, out_valid, !busy)
  `FBS_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy && !out_valid)
  `FBS_ASSERT_IMPL(a_skip_only_with_strobe, clk, rst_n, out_skip, out_valid)
  `FBS_ASSERT_NEXT(a_no_throttle_no_skip, clk, rst_n,
                   state_r == fbs_pkg::ST_CHK && !throttle, out_valid && !out_skip)

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for failure_backoff_skip: directed and random requests,
// results predicted per slot and compared in order by a small scoreboard class
// depends on fbs_pkg and the failure_backoff_skip rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int MILD_NUM      = 7;
  localparam int SEVERE_NUM    = 9;
  localparam int RATIO_DEN     = 10;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int DRAIN_CYCLES  = 24;
  localparam int MAX_REPORTS   = 10;
  localparam int HOT_SLOT      = 5;

  typedef struct {
    bit [5:0]  slot_id;
    bit        present;
    bit [15:0] obs;
    bit [23:0] succ;
    bit [23:0] fail;
    bit [16:0] thr;
    bit [15:0] base;
  } skip_request_t;

  class backoff_scoreboard;
    bit [fbs_pkg::PHASE_W-1:0] phase_mem [fbs_pkg::SLOT_COUNT];
    bit               pending_skips [$];
    int               mismatches;

    function bit decide_skip(skip_request_t r);
      longint unsigned s, f, tot, thr;
      int unsigned base, period;
      bit [fbs_pkg::PHASE_W-1:0] phase;
      if (!r.present || r.slot_id >= fbs_pkg::SLOT_COUNT) return 1'b0;
      if (r.obs < fbs_pkg::MIN_OBSERVATIONS) return 1'b0;
      s = r.succ;
      f = r.fail;
      if (f <= s) return 1'b0;
      thr = r.thr;
      if (thr == 0 || thr > fbs_pkg::THRESHOLD_ONE) thr = fbs_pkg::DEFAULT_THRESHOLD;
      base = (r.base == 0) ? fbs_pkg::DEFAULT_PERIOD : r.base;
      tot = s + f;
      if (f * fbs_pkg::THRESHOLD_ONE < thr * tot) return 1'b0;
      period = base;
      if (RATIO_DEN * f <= MILD_NUM * tot) begin
        period = base / 2;
        if (period < fbs_pkg::MIN_MILD_PERIOD) period = fbs_pkg::MIN_MILD_PERIOD;
      end else if (RATIO_DEN * f > SEVERE_NUM * tot) begin
        period = base * 2;
      end
      phase = phase_mem[r.slot_id] + 1'b1;
      phase_mem[r.slot_id] = phase;
      return (phase % period) != 0;
    endfunction

    function void note_request(skip_request_t r);
      pending_skips.push_back(decide_skip(r));
    endfunction

    function void check_result(bit got);
      bit want;
      if (pending_skips.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result skip=%0b", $realtime, got);
        mismatches++;
        return;
      end
      want = pending_skips.pop_front();
      if (got !== want) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: skip mismatch expected %0b actual %0b", $realtime, want, got);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_skips.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [5:0]  in_slot_id;
  logic        in_slot_present;
  logic [15:0] in_observation_count;
  logic [23:0] in_success_weight;
  logic [23:0] in_failure_weight;
  logic [16:0] in_skip_threshold;
  logic [15:0] in_base_period;
  logic        out_valid;
  logic        out_skip;

  backoff_scoreboard skip_board = new();

  failure_backoff_skip uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_slot_id           (in_slot_id),
    .in_slot_present      (in_slot_present),
    .in_observation_count (in_observation_count),
    .in_success_weight    (in_success_weight),
    .in_failure_weight    (in_failure_weight),
    .in_skip_threshold    (in_skip_threshold),
    .in_base_period       (in_base_period),
    .out_valid            (out_valid),
    .out_skip             (out_skip)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) skip_board.check_result(out_skip);
  end

  task automatic send_request(skip_request_t r);
    @(negedge clk);
    start                <= 1'b1;
    in_slot_id           <= r.slot_id;
    in_slot_present      <= r.present;
    in_observation_count <= r.obs;
    in_success_weight    <= r.succ;
    in_failure_weight    <= r.fail;
    in_skip_threshold    <= r.thr;
    in_base_period       <= r.base;
    do @(posedge clk); while (busy);
    skip_board.note_request(r);
  endtask

  task automatic send_fields(bit [5:0] slot, bit pres, bit [15:0] obs, bit [23:0] s,
                             bit [23:0] f, bit [16:0] thr, bit [15:0] base);
    skip_request_t r;
    r = '{slot, pres, obs, s, f, thr, base};
    send_request(r);
  endtask

  // fields carry noise while start is low
  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start                <= 1'b0;
      in_slot_id           <= 6'($urandom);
      in_slot_present      <= 1'($urandom);
      in_observation_count <= 16'($urandom);
      in_success_weight    <= 24'($urandom);
      in_failure_weight    <= 24'($urandom);
      in_skip_threshold    <= 17'($urandom);
      in_base_period       <= 16'($urandom);
    end
  endtask

  function automatic skip_request_t random_request();
    skip_request_t r;
    int kind;
    int wbits;
    kind = $urandom_range(0, 9);
    r.slot_id = ($urandom_range(0, 2) == 0) ? 6'(HOT_SLOT) : 6'($urandom_range(0, 63));
    r.present = 1'b1;
    r.obs = ($urandom_range(0, 3) == 0) ?
            16'(fbs_pkg::MIN_OBSERVATIONS + $urandom_range(0, 3)) :
            16'($urandom_range(4, 65535));
    wbits = $urandom_range(1, 24);
    r.fail = 24'($urandom_range(1, (1 << wbits) - 1));
    case ($urandom_range(0, 2))
      0: r.succ = 24'($urandom_range(0, r.fail / 10));
      1: r.succ = 24'($urandom_range(r.fail / 9, (3 * r.fail) / 7));
      default: r.succ = 24'($urandom_range((3 * r.fail) / 7, r.fail - 1));
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2: r.thr = 17'($urandom_range(32769, 65536));
      3: r.thr = 17'd0;
      4, 5: r.thr = 17'($urandom_range(65537, 131071));
      default: r.thr = 17'($urandom_range(1, 32768));
    endcase
    r.base = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    case (kind)
      0: r = '{6'($urandom), 1'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
               17'($urandom), 16'($urandom)};
      8: begin
        if ($urandom_range(0, 1) == 0) r.present = 1'b0;
        else r.obs = 16'($urandom_range(0, 3));
      end
      9: r.succ = 24'($urandom_range(r.fail, 24'hFFFFFF));
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    int burst_left;
    rst_n                = 1'b0;
    start                = 1'b0;
    in_slot_id           = '0;
    in_slot_present      = 1'b0;
    in_observation_count = '0;
    in_success_weight    = '0;
    in_failure_weight    = '0;
    in_skip_threshold    = '0;
    in_base_period       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // absent slot, observation boundary, weight ties, threshold and period corners
    send_fields(6'd0,  1'b0, 16'd100,   24'd10,      24'd1000,    17'd1,      16'd4);
    send_fields(6'd63, 1'b1, 16'd3,     24'd10,      24'd1000,    17'd1,      16'd4);
    send_fields(6'd63, 1'b1, 16'd4,     24'd10,      24'd1000,    17'd1,      16'd4);
    send_fields(6'd1,  1'b1, 16'hFFFF,  24'd500,     24'd500,     17'd1,      16'd4);
    send_fields(6'd1,  1'b1, 16'hFFFF,  24'd500,     24'd501,     17'd1,      16'd4);
    send_fields(6'd2,  1'b1, 16'd100,   24'd1,       24'd3,       17'd49152,  16'd6);
    send_fields(6'd2,  1'b1, 16'd100,   24'd1,       24'd3,       17'd49153,  16'd6);
    send_fields(6'd3,  1'b1, 16'd100,   24'd3,       24'd7,       17'd0,      16'd1);
    send_fields(6'd3,  1'b1, 16'd100,   24'd3,       24'd7,       17'd65536,  16'd3);
    send_fields(6'd3,  1'b1, 16'd100,   24'd0,       24'd7,       17'd65536,  16'd3);
    send_fields(6'd4,  1'b1, 16'd100,   24'd3,       24'd7,       17'd65537,  16'd0);
    send_fields(6'd4,  1'b1, 16'd100,   24'd3,       24'd7,       17'h1FFFF,  16'hFFFF);
    send_fields(6'd5,  1'b1, 16'd100,   24'd1,       24'd99,      17'd1,      16'hFFFF);
    send_fields(6'd6,  1'b1, 16'hFFFF,  24'hFFFFFE,  24'hFFFFFF,  17'd1,      16'd2);
    send_fields(6'd6,  1'b1, 16'hFFFF,  24'd0,       24'hFFFFFF,  17'd32768,  16'hFFFF);
    send_fields(6'd7,  1'b1, 16'd4,     24'd1,       24'd9,       17'd1,      16'd5);
    send_fields(6'd7,  1'b1, 16'd4,     24'd0,       24'd0,       17'd1,      16'd5);
    send_fields(6'd8,  1'b1, 16'd100,   24'd1,       24'd2,       17'd43690,  16'd3);
    repeat (4) send_fields(6'd9, 1'b1, 16'd50, 24'd2, 24'd9, 17'd1, 16'd3);
    hold_off(3);

    burst_left = 0;
    repeat (RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
      send_request(random_request());
      burst_left--;
    end
    hold_off(1);

    while (skip_board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (skip_board.mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
